// ----- hw/rtl/lru_pkg.sv -----
// shared types and constants for the lru key-value cache
package lru_pkg;

  localparam int KeyW = 31;
  localparam int ValW = 31;
  localparam int CapW = 5;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  localparam logic CmdGet = 1'b0;
  localparam logic CmdPut = 1'b1;

  // controller to datapath, one bit per sequencer step
  typedef struct packed {
    logic load;
    logic match;
    logic decide;
    logic link;
    logic tail;
  } lru_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic put;
  } lru_sts_t;

endpackage

// ----- hw/rtl/lru_ram.sv -----
// generic single write port, single read port ram with registered read
module lru_ram #(
  parameter int Width = 31,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/lru_ctrl.sv -----
// sequencer for the lru cache: accept, match, decide, link, tail
module lru_ctrl
  import lru_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  lru_sts_t sts_i,
  output lru_cmd_t cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StMatch  = 5'b00010,
    StDecide = 5'b00100,
    StLink   = 5'b01000,
    StTail   = 5'b10000
  } lru_state_e;

  lru_state_e state_q, state_d;
  logic       done_q, done_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StMatch;
        end
      end
      StMatch:  state_d = StDecide;
      StDecide: begin
        // a get that misses has no links to touch
        if (sts_i.hit || sts_i.put) begin
          state_d = StLink;
        end else begin
          state_d = StTail;
        end
      end
      StLink:   state_d = StTail;
      StTail:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  assign done_d = (state_q == StTail);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o        = (state_q != StIdle);
  assign done_o        = done_q;
  assign cmd_o.load    = (state_q == StIdle) && start_i;
  assign cmd_o.match   = (state_q == StMatch);
  assign cmd_o.decide  = (state_q == StDecide);
  assign cmd_o.link    = (state_q == StLink);
  assign cmd_o.tail    = (state_q == StTail);

endmodule

// ----- hw/rtl/lru_dp.sv -----
// lru cache datapath: key match array, entry memories, recency chain
module lru_dp
  import lru_pkg::*;
#(
  parameter int Entries = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lru_cmd_t        cmd_i,
  output lru_sts_t        sts_o,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  input  logic            command_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [ValW-1:0] value_i,
  output logic            hit_o,
  output logic [ValW-1:0] read_value_o,
  output logic            evicted_o,
  output logic [KeyW-1:0] evicted_key_o
);

  localparam int SlotW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CntW  = $clog2(Entries + 1);

  // request registers
  logic            cmd_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;

  // key copies for the parallel match
  logic [KeyW-1:0]    ckey_q [Entries];
  logic [Entries-1:0] match_q, match_d;

  logic             hit_q, evict_q;
  logic [SlotW-1:0] slot_q;

  logic [CntW-1:0]  used_q, used_d;
  logic [SlotW-1:0] oldest_q, oldest_d;
  logic [SlotW-1:0] newest_q, newest_d;
  logic [CapW-1:0]  cap_q;

  logic             hit_w;
  logic [SlotW-1:0] found_w;
  logic [CapW-1:0]  cap_nz;
  logic             evict_w;
  logic [CntW-1:0]  used_after;

  // memory ports
  logic [KeyW-1:0]  keym_rd;
  logic [ValW-1:0]  valm_rd;
  logic [SlotW-1:0] older_rd, newer_rd;
  logic             older_we, newer_we;
  logic [SlotW-1:0] older_waddr, older_wdata, newer_waddr, newer_wdata;
  logic             ins_we, val_we;
  logic             unlink_mid, tail_link;

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      match_d[i] = (CntW'(i) < used_q) && (ckey_q[i] == key_q);
    end
  end

  // valid keys are unique, so the match vector is one-hot or empty
  always_comb begin
    found_w = '0;
    for (int i = 0; i < Entries; i++) begin
      if (match_q[i]) begin
        found_w = found_w | SlotW'(i);
      end
    end
  end

  assign hit_w   = |match_q;
  assign cap_nz  = (cap_q == '0) ? CapW'(1) : cap_q;
  assign evict_w = (cmd_q == CmdPut) && !hit_w && (used_q != '0) &&
                   ((32'(used_q) >= 32'(cap_nz)) || (32'(used_q) == 32'(Entries)));

  assign used_after = used_q - CntW'(evict_q);

  assign sts_o.hit = hit_w;
  assign sts_o.put = (cmd_q == CmdPut);

  // link step of a hit: splice the entry out of the middle of the chain
  assign unlink_mid = cmd_i.link && hit_q && (slot_q != newest_q) && (slot_q != oldest_q);
  // tail step: hang the entry after the current newest
  assign tail_link  = cmd_i.tail &&
                      (hit_q ? (slot_q != newest_q)
                             : ((cmd_q == CmdPut) && (used_after != '0)));
  assign ins_we     = cmd_i.link && !hit_q && (cmd_q == CmdPut);
  assign val_we     = cmd_i.link && (cmd_q == CmdPut);

  always_comb begin
    newer_we    = unlink_mid || tail_link;
    older_we    = unlink_mid || tail_link;
    newer_waddr = newest_q;
    newer_wdata = slot_q;
    older_waddr = slot_q;
    older_wdata = newest_q;
    if (cmd_i.link) begin
      newer_waddr = older_rd;
      newer_wdata = newer_rd;
      older_waddr = newer_rd;
      older_wdata = older_rd;
    end
  end

  always_comb begin
    oldest_d = oldest_q;
    newest_d = newest_q;
    used_d   = used_q;
    if (cmd_i.link) begin
      if (hit_q) begin
        if ((slot_q != newest_q) && (slot_q == oldest_q)) begin
          oldest_d = newer_rd;
        end
      end else if (evict_q && (used_q > CntW'(1))) begin
        oldest_d = newer_rd;
      end
    end
    if (cmd_i.tail) begin
      if (hit_q) begin
        newest_d = slot_q;
      end else if (cmd_q == CmdPut) begin
        if (used_after == '0) begin
          oldest_d = slot_q;
        end
        newest_d = slot_q;
        used_d   = used_after + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      oldest_q <= '0;
      newest_q <= '0;
      cap_q    <= CapReset;
    end else begin
      used_q   <= used_d;
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    if (cmd_i.match) begin
      match_q <= match_d;
    end
    if (cmd_i.decide) begin
      hit_q   <= hit_w;
      evict_q <= evict_w;
      if (hit_w) begin
        slot_q <= found_w;
      end else if (evict_w) begin
        slot_q <= oldest_q;
      end else begin
        slot_q <= used_q[SlotW-1:0];
      end
    end
    if (ins_we) begin
      ckey_q[slot_q] <= key_q;
    end
    if (cmd_i.tail) begin
      hit_o         <= hit_q;
      read_value_o  <= (hit_q && (cmd_q == CmdGet)) ? valm_rd : '0;
      evicted_o     <= evict_q;
      evicted_key_o <= evict_q ? keym_rd : '0;
    end
  end

  lru_ram #(.Width(KeyW), .Depth(Entries)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ins_we),
    .waddr_i (slot_q),
    .wdata_i (key_q),
    .re_i    (cmd_i.decide),
    .raddr_i (oldest_q),
    .rdata_o (keym_rd)
  );

  lru_ram #(.Width(ValW), .Depth(Entries)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (slot_q),
    .wdata_i (val_q),
    .re_i    (cmd_i.decide),
    .raddr_i (found_w),
    .rdata_o (valm_rd)
  );

  lru_ram #(.Width(SlotW), .Depth(Entries)) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (older_we),
    .waddr_i (older_waddr),
    .wdata_i (older_wdata),
    .re_i    (cmd_i.decide),
    .raddr_i (found_w),
    .rdata_o (older_rd)
  );

  lru_ram #(.Width(SlotW), .Depth(Entries)) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (newer_we),
    .waddr_i (newer_waddr),
    .wdata_i (newer_wdata),
    .re_i    (cmd_i.decide),
    .raddr_i (hit_w ? found_w : oldest_q),
    .rdata_o (newer_rd)
  );

endmodule

// ----- hw/rtl/lru_cache_get_put.sv -----
// top level of the lru key-value cache with get and put requests
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  request  | start_i high, busy_o low| command_i, key_i, value_i
//  result   | done_o, one cycle       | hit_o, read_value_o, evicted_o, evicted_key_o
//  config   | cfg_we_i                | cfg_wdata_i (capacity)
//
//  a get that misses skips the link step, every other request passes through
//  the match, decide, link and tail steps of the sequencer, with one write per
//  link memory per step; busy_o falls as done_o rises, so a new request can
//  follow only once the result of the last one shows.
//  reset empties the cache (fill count and chain ends to zero) and sets the
//  capacity to 16; there is no clearing pass. the receiver cannot stall.
module lru_cache_get_put
  import lru_pkg::*;
#(
  parameter int Entries = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic            command_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [ValW-1:0] value_i,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  output logic            done_o,
  output logic            hit_o,
  output logic [ValW-1:0] read_value_o,
  output logic            evicted_o,
  output logic [KeyW-1:0] evicted_key_o
);

  lru_cmd_t cmd;
  lru_sts_t sts;

  lru_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  lru_dp #(.Entries(Entries)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .command_i     (command_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while sequencer busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but sequencer did not start");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evicted_o) |-> !hit_o)
    else $error("eviction reported on a hit");

  a_value_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (read_value_o != '0)) |-> (hit_o && !evicted_o))
    else $error("read value without a get hit");

  a_tail_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.tail |=> done_o)
    else $error("tail step without result strobe");

endmodule
